[src/crts_pkg.sv]
// ----------------------------------------------------------------------------
// crts_pkg
// Shared types and constants for the clipped rectangle tile layer scanner.
// ----------------------------------------------------------------------------
package crts_pkg;

   // store geometry
   localparam int MAX_LAYERS = 4;
   localparam int MAX_TILES  = 4096;
   localparam int IDX_W      = $clog2(MAX_TILES);
   localparam int LAYER_W    = 2;
   localparam int ENTRY_W    = 2;
   localparam int ROW_W      = ENTRY_W * MAX_LAYERS;

   // register and field widths
   localparam int DIM_W  = 13;
   localparam int RECT_W = 14;
   localparam int SEL_W  = 3;
   localparam int NUM_W  = 3;
   localparam int CFG_W  = 14;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W = $clog2(MAX_LAYERS + 1);
   localparam int CUR_W  = ((IDX_W > DIM_W) ? IDX_W : DIM_W) + 1;

   // stream words
   localparam int REQ_W = 24;
   localparam int RSP_W = 16;

   // commands
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_TAKE  = 2'd1,
      CMD_PEEK  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CFG_MAP_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_MAP_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_RECT_X       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_RECT_Y       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_RECT_W       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_RECT_H       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_LAYER_SELECT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CFG_LAYERS_USED  = 3'd7;

   // single-lane write into the tile store
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   addr;
      logic [LAYER_W-1:0] layer;
      logic [ENTRY_W-1:0] bits;   // {solid, present}
   } store_wr_type;

endpackage

[src/crts_store.sv]
// ----------------------------------------------------------------------------
// crts_store
// Tile store: one row per tile index holding {solid, present} for every
// layer. Lane writes, registered reads, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module crts_store import crts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  store_wr_type       wr,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ROW_W-1:0]   rd_data,
   output logic               busy
);

   logic [ROW_W-1:0] tile_mem [MAX_TILES];

   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic             busy_ff, busy_in;
   logic [ROW_W-1:0] rd_data_ff;

   // clearing pass sequencing
   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in     = busy_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_W'(MAX_TILES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         busy_ff     <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         busy_ff     <= busy_in;
      end
   end

   // memory write port: whole-row clear or one layer lane
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         tile_mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         tile_mem[wr.addr][{wr.layer, 1'b0} +: ENTRY_W] <= wr.bits;
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tile_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

[src/clipped_rect_tile_layer_scanner.sv]
// ----------------------------------------------------------------------------
// clipped_rect_tile_layer_scanner
// Scans a map rectangle, clipped to the map, over a layered tile store.
// Start passes through the clip and setup states; peek/take walk the store
// tile by tile unless a hit is already held; write goes straight to the result.
// One command in flight; the next is accepted once the result is registered.
// Reset: synchronous; the store is cleared row by row after reset, and no
// command is accepted meanwhile (configuration writes are).
// ----------------------------------------------------------------------------
module clipped_rect_tile_layer_scanner import crts_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // command stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [1:0] cmd, [3:2] entry_layer, [15:4] entry_index,
   // [16] entry_present, [17] entry_solid, [23:18] zero
   input  logic [REQ_W-1:0]     req_tdata,
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [0] found, [12:1] hit_index, [14:13] hit_layer, [15] zero
   output logic [RSP_W-1:0]     rsp_tdata,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_CLIP  = 6'b000100,
      S_SETUP = 6'b001000,
      S_WALK  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   // configuration registers
   logic        [DIM_W-1:0]  map_width_ff, map_height_ff;
   logic signed [RECT_W-1:0] rect_x_ff, rect_y_ff, rect_w_ff, rect_h_ff;
   logic        [SEL_W-1:0]  layer_select_ff;
   logic        [NUM_W-1:0]  layers_used_ff;

   // scan state
   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [CUR_W-1:0]        cursor_ff, cursor_in;
   logic [DIM_W-1:0]        cols_ff, cols_in;
   logic [DIM_W-1:0]        rows_ff, rows_in;
   logic [DIM_W-1:0]        clip_w_ff, clip_w_in;
   logic [DIM_W-1:0]        row_skip_ff, row_skip_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [LAYER_W-1:0]      cur_layer_ff, cur_layer_in;
   logic                    found_ff, found_in;
   logic                    hit_ready_ff, hit_ready_in;
   logic                    scan_all_ff, scan_all_in;
   logic [LAYER_W-1:0]      scan_lay_ff, scan_lay_in;

   // clip stage
   logic [DIM_W-1:0]        x_c_ff, x_c_in;
   logic [DIM_W-1:0]        w_c_ff, w_c_in;
   logic [DIM_W-1:0]        h_c_ff, h_c_in;
   logic [2*DIM_W-1:0]      prod_ff, prod_in;
   logic                    empty_ff, empty_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   // store interface
   store_wr_type            st_wr;
   logic                    st_rd_en;
   logic [IDX_W-1:0]        st_rd_addr;
   logic [ROW_W-1:0]        st_rd_data;
   logic                    st_busy;

   logic                    req_fire;
   cmd_type                 req_cmd;
   logic [NUM_W-1:0]        nl;

   crts_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (st_wr),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data),
      .busy    (st_busy)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tdata[1:0]);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // layers in use, saturated to the number of layers the store holds
   assign nl = (layers_used_ff > NUM_W'(MAX_LAYERS)) ? NUM_W'(MAX_LAYERS) : layers_used_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff    <= DIM_W'(64);
         map_height_ff   <= DIM_W'(64);
         rect_x_ff       <= '0;
         rect_y_ff       <= '0;
         rect_w_ff       <= '0;
         rect_h_ff       <= '0;
         layer_select_ff <= '1;
         layers_used_ff  <= NUM_W'(4);
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_MAP_WIDTH:    map_width_ff    <= csr_wdata[DIM_W-1:0];
            CFG_MAP_HEIGHT:   map_height_ff   <= csr_wdata[DIM_W-1:0];
            CFG_RECT_X:       rect_x_ff       <= csr_wdata[RECT_W-1:0];
            CFG_RECT_Y:       rect_y_ff       <= csr_wdata[RECT_W-1:0];
            CFG_RECT_W:       rect_w_ff       <= csr_wdata[RECT_W-1:0];
            CFG_RECT_H:       rect_h_ff       <= csr_wdata[RECT_W-1:0];
            CFG_LAYER_SELECT: layer_select_ff <= csr_wdata[SEL_W-1:0];
            CFG_LAYERS_USED:  layers_used_ff  <= csr_wdata[NUM_W-1:0];
            default: ;
         endcase
      end
   end

   // rectangle clipping against the map
   logic signed [15:0] cx, cy, cw, ch, mw_s, mh_s;
   always_comb begin
      cx   = 16'(rect_x_ff);
      cy   = 16'(rect_y_ff);
      cw   = 16'(rect_w_ff);
      ch   = 16'(rect_h_ff);
      mw_s = signed'({3'b000, map_width_ff});
      mh_s = signed'({3'b000, map_height_ff});
      if (cx < 0) begin
         cw = cw + cx;
         cx = '0;
      end
      if (cy < 0) begin
         ch = ch + cy;
         cy = '0;
      end
      if (cx + cw > mw_s) begin
         cw = mw_s - cx;
      end
      if (cy + ch > mh_s) begin
         ch = mh_s - cy;
      end
      empty_in = (cw <= 0) || (ch <= 0) || (cx >= mw_s) || (cy >= mh_s);
      x_c_in   = cx[DIM_W-1:0];
      w_c_in   = cw[DIM_W-1:0];
      h_c_in   = ch[DIM_W-1:0];
      prod_in  = (2*DIM_W)'(cy[DIM_W-1:0]) * (2*DIM_W)'(map_width_ff);
   end

   // first present layer of the fetched row that the walk may visit
   logic                pick_hit;
   logic [LAYER_W-1:0]  pick_lay;
   logic                pick_solid;
   always_comb begin
      logic cand;
      pick_hit   = 1'b0;
      pick_lay   = '0;
      pick_solid = 1'b0;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         if (scan_all_ff) begin
            cand = st_rd_data[ENTRY_W*l] && (STEP_W'(l) >= step_ff) && (NUM_W'(l) < nl);
         end else begin
            cand = st_rd_data[ENTRY_W*l] && (LAYER_W'(l) == scan_lay_ff) &&
                   (step_ff == '0) && (NUM_W'(l) < nl);
         end
         if (!pick_hit && cand) begin
            pick_hit   = 1'b1;
            pick_lay   = LAYER_W'(l);
            pick_solid = st_rd_data[ENTRY_W*l+1];
         end
      end
   end

   // start cursor and next-tile arithmetic
   logic [2*DIM_W:0]  start_sum;
   logic [CUR_W-1:0]  c_next1, c_adv;
   assign start_sum = (2*DIM_W+1)'(x_c_ff) + (2*DIM_W+1)'(prod_ff);
   assign c_next1   = cursor_ff + 1'b1;

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cursor_in    = cursor_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      clip_w_in    = clip_w_ff;
      row_skip_in  = row_skip_ff;
      step_in      = step_ff;
      cur_layer_in = cur_layer_ff;
      found_in     = found_ff;
      hit_ready_in = hit_ready_ff;
      scan_all_in  = scan_all_ff;
      scan_lay_in  = scan_lay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      st_wr        = '0;
      st_rd_en     = 1'b0;
      st_rd_addr   = cursor_ff[IDX_W-1:0];
      c_adv        = c_next1;

      unique case (state_ff)
         S_CLEAR: begin
            if (!st_busy) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               cmd_in = req_cmd;
               case (req_cmd)
                  CMD_START: state_in = S_CLIP;
                  CMD_WRITE: begin
                     st_wr.en    = 1'b1;
                     st_wr.layer = req_tdata[3:2];
                     st_wr.addr  = req_tdata[15:4];
                     st_wr.bits  = {req_tdata[17], req_tdata[16]};
                     state_in    = S_RESP;
                  end
                  default: begin
                     // peek or take: fetch unless a hit is already held
                     state_in = S_RESP;
                     if (!hit_ready_ff) begin
                        hit_ready_in = 1'b1;
                        if ((rows_ff == '0) || (cursor_ff >= CUR_W'(MAX_TILES))) begin
                           rows_in  = '0;
                           found_in = 1'b0;
                        end else begin
                           st_rd_en = 1'b1;
                           state_in = S_WALK;
                        end
                     end
                  end
               endcase
            end
         end

         S_CLIP: state_in = S_SETUP;

         S_SETUP: begin
            scan_all_in  = layer_select_ff[SEL_W-1];
            scan_lay_in  = layer_select_ff[LAYER_W-1:0];
            step_in      = '0;
            cur_layer_in = '0;
            found_in     = 1'b0;
            hit_ready_in = 1'b0;
            if (empty_ff) begin
               cursor_in   = '0;
               cols_in     = '0;
               rows_in     = '0;
               clip_w_in   = '0;
               row_skip_in = '0;
            end else begin
               if (start_sum >= (2*DIM_W+1)'(MAX_TILES)) begin
                  cursor_in = CUR_W'(MAX_TILES);
               end else begin
                  cursor_in = CUR_W'(start_sum);
               end
               row_skip_in = map_width_ff - w_c_ff;
               cols_in     = w_c_ff;
               rows_in     = h_c_ff;
               clip_w_in   = w_c_ff;
            end
            state_in = S_RESP;
         end

         S_WALK: begin
            if (pick_hit) begin
               cur_layer_in = pick_lay;
               step_in      = pick_solid ? STEP_W'(nl) : STEP_W'(pick_lay) + 1'b1;
               found_in     = 1'b1;
               state_in     = S_RESP;
            end else begin
               // tile finished: move to the next tile of the rectangle
               step_in = '0;
               if (cols_ff <= DIM_W'(1)) begin
                  cols_in = clip_w_ff;
                  c_adv   = c_next1 + CUR_W'(row_skip_ff);
                  rows_in = rows_ff - 1'b1;
               end else begin
                  cols_in = cols_ff - 1'b1;
               end
               if ((cols_ff <= DIM_W'(1)) && (rows_ff <= DIM_W'(1))) begin
                  cursor_in = c_next1;
                  rows_in   = '0;
                  found_in  = 1'b0;
                  state_in  = S_RESP;
               end else begin
                  cursor_in = c_adv;
                  if (c_adv >= CUR_W'(MAX_TILES)) begin
                     rows_in  = '0;
                     found_in = 1'b0;
                     state_in = S_RESP;
                  end else begin
                     st_rd_en   = 1'b1;
                     st_rd_addr = c_adv[IDX_W-1:0];
                  end
               end
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (((cmd_ff == CMD_TAKE) || (cmd_ff == CMD_PEEK)) && found_ff) begin
                  rsp_data_in = {1'b0, cur_layer_ff, cursor_ff[IDX_W-1:0], 1'b1};
               end
               if (cmd_ff == CMD_TAKE) begin
                  hit_ready_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_CLEAR;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cmd_ff       <= CMD_START;
         cursor_ff    <= '0;
         cols_ff      <= '0;
         rows_ff      <= '0;
         clip_w_ff    <= '0;
         row_skip_ff  <= '0;
         step_ff      <= '0;
         cur_layer_ff <= '0;
         found_ff     <= 1'b0;
         hit_ready_ff <= 1'b0;
         scan_all_ff  <= 1'b1;
         scan_lay_ff  <= '1;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         cursor_ff    <= cursor_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         clip_w_ff    <= clip_w_in;
         row_skip_ff  <= row_skip_in;
         step_ff      <= step_in;
         cur_layer_ff <= cur_layer_in;
         found_ff     <= found_in;
         hit_ready_ff <= hit_ready_in;
         scan_all_ff  <= scan_all_in;
         scan_lay_ff  <= scan_lay_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // clip stage payload
   always_ff @(posedge clock) begin
      if (state_ff == S_CLIP) begin
         x_c_ff   <= x_c_in;
         w_c_ff   <= w_c_in;
         h_c_ff   <= h_c_in;
         prod_ff  <= prod_in;
         empty_ff <= empty_in;
      end
   end

endmodule
